FILE: hw/rtl/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies; imported by the interfaces, the cell and the top level
`default_nettype none

package ffba_pkg;

  localparam int ADDR_W   = 32;
  localparam int REQ_W    = 24;
  localparam int STATUS_W = 3;
  localparam int ROUND_W  = REQ_W + 1;
  // wide enough for base + header + size without wrap
  localparam int BRK_W    = ADDR_W + 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NULL    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_LIMIT   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd4;

  localparam int PADDR_W = 3;
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RESET  = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 32'hFFFF_FFFF;

  // control part of the token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic func;
    logic seek;
    logic hit;
  } ffba_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffba_if.sv
// request and response channel interfaces of the block allocator
// depends on ffba_pkg for field widths
`default_nettype none

interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [REQ_W-1:0]  req_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, func, req_size, free_addr, input ready);
  modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   addr;
  logic [STATUS_W-1:0] status;
  logic                reused;

  modport source (output valid, addr, status, reused, input ready);
  modport sink   (input valid, addr, status, reused, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator.sv
// Heap allocator with a table of MAX_BLOCKS blocks kept in creation order, one
// entry per cell of a chain. A request's token walks the whole cell chain, one
// cell per cycle, where the first free block large enough (allocate) or the
// block with the matching header (free) takes it; the end of the walk is
// latched on entry to the finish state, which appends a new block at the break
// when needed and writes the result register. A result that waits in the
// output register holds the final step of the following request until it is
// taken. One request is in flight at a time; the result register lets the
// next request in while a result waits. Freed blocks are reused whole, never
// split. Config (APB, heap_base at 0x0, heap_limit at 0x4) should be written
// while idle; a new heap_base applies only while the table holds no block.
// depends on ffba_pkg, ffba_if and ffba_cell
`default_nettype none

module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12,
  parameter int SIZE_BITS    = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  ffba_req_if.sink                req,
  ffba_rsp_if.source              rsp
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int RW    = (ROUND_W > SIZE_BITS) ? ROUND_W : SIZE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state;
  logic [ADDR_W-1:0]    heap_base;
  logic [ADDR_W-1:0]    heap_limit;
  logic [ADDR_W-1:0]    heap_break;
  logic [ADDR_W-1:0]    heap_break_next;
  logic [CNT_W-1:0]     block_count;

  logic                 cur_func;
  logic [STATUS_W-1:0]  cur_pre;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 tail_hit;
  logic [ADDR_W-1:0]    tail_found;

  logic                 out_v;
  logic [ADDR_W-1:0]    out_addr;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_reused;

  logic [ROUND_W-1:0]   rounded;
  logic [RW-1:0]        rounded_ext;
  logic                 fits;
  logic [STATUS_W-1:0]  pre_status;
  logic                 in_take;

  ffba_tok_t            tok   [MAX_BLOCKS+1];
  logic [ADDR_W-1:0]    key   [MAX_BLOCKS+1];
  logic [ADDR_W-1:0]    found [MAX_BLOCKS+1];

  logic                 commit;
  logic                 wr_en;
  logic [ADDR_W-1:0]    base;
  logic [BRK_W-1:0]     next_break;
  logic [ADDR_W-1:0]    res_addr;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_reused;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? heap_limit : heap_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= HEAP_BASE_RESET;
      heap_limit <= HEAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEAP_BASE) begin
        heap_base <= pwdata;
      end else begin
        heap_limit <= pwdata;
      end
    end
  end

  // request entry: round the size and build the chain token
  assign rounded     = (ROUND_W'(req.req_size) + ROUND_W'(3)) & ~ROUND_W'(3);
  assign rounded_ext = RW'(rounded);
  assign fits        = rounded_ext <= RW'({SIZE_BITS{1'b1}});

  always_comb begin
    if (req.func == FUNC_ALLOC) begin
      priority if (req.req_size == '0) begin
        pre_status = STAT_NULL;
      end else if (!fits) begin
        pre_status = STAT_LIMIT;
      end else begin
        pre_status = STAT_OK;
      end
    end else begin
      pre_status = (req.free_addr == '0) ? STAT_NULL : STAT_OK;
    end
  end

  assign req.ready = (state == S_IDLE) && !rst;
  assign in_take   = req.valid && req.ready;

  assign tok[0].valid = in_take;
  assign tok[0].func  = req.func;
  assign tok[0].seek  = (pre_status == STAT_OK);
  assign tok[0].hit   = 1'b0;
  assign key[0]       = (req.func == FUNC_FREE) ?
                        (req.free_addr - ADDR_W'(HEADER_BYTES)) :
                        ADDR_W'(SIZE_BITS'(rounded_ext));
  assign found[0]     = '0;

  assign wr_en = commit && (cur_pre == STAT_OK) && !tail_hit && (cur_func == FUNC_ALLOC)
                 && (res_status == STAT_OK);

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .IDX_W(IDX_W), .CNT_W(CNT_W), .SIZE_BITS(SIZE_BITS), .IDX(g)
    ) u_cell (
      .clk(clk), .rst(rst), .count(block_count),
      .wr_en(wr_en), .wr_idx(block_count[IDX_W-1:0]),
      .wr_start(base), .wr_size(cur_size),
      .tok_in(tok[g]), .key_in(key[g]), .found_in(found[g]),
      .tok_out(tok[g+1]), .key_out(key[g+1]), .found_out(found[g+1])
    );
  end

  // result of a finished walk
  assign base       = (block_count == '0) ? heap_base : heap_break;
  assign next_break = BRK_W'(base) + BRK_W'(HEADER_BYTES) + BRK_W'(cur_size);
  assign commit     = (state == S_FIN) && (!out_v || rsp.ready);

  always_comb begin
    res_addr        = '0;
    res_reused      = 1'b0;
    heap_break_next = heap_break;
    priority if (cur_pre != STAT_OK) begin
      res_status = cur_pre;
    end else if (tail_hit) begin
      res_status = STAT_OK;
      if (cur_func == FUNC_ALLOC) begin
        res_addr   = tail_found + ADDR_W'(HEADER_BYTES);
        res_reused = 1'b1;
      end
    end else if (cur_func == FUNC_FREE) begin
      res_status = STAT_UNKNOWN;
    end else if (block_count == CNT_W'(MAX_BLOCKS)) begin
      res_status = STAT_FULL;
    end else if (next_break > BRK_W'(heap_limit)) begin
      res_status = STAT_LIMIT;
    end else begin
      res_status      = STAT_OK;
      res_addr        = base + ADDR_W'(HEADER_BYTES);
      heap_break_next = next_break[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      block_count <= '0;
      heap_break  <= '0;
      out_v       <= 1'b0;
    end else begin
      if (commit) begin
        out_v <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok[MAX_BLOCKS].valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit) begin
            heap_break <= heap_break_next;
            if (wr_en) begin
              block_count <= block_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_func <= req.func;
      cur_pre  <= pre_status;
      cur_size <= SIZE_BITS'(rounded_ext);
    end
    if (tok[MAX_BLOCKS].valid) begin
      tail_hit   <= tok[MAX_BLOCKS].hit;
      tail_found <= found[MAX_BLOCKS];
    end
    if (commit) begin
      out_addr   <= res_addr;
      out_status <= res_status;
      out_reused <= res_reused;
    end
  end

  assign rsp.valid  = out_v;
  assign rsp.addr   = out_addr;
  assign rsp.status = out_status;
  assign rsp.reused = out_reused;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    block_count <= CNT_W'(MAX_BLOCKS))
    else $error("block count beyond table size");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_BLOCKS].valid |-> state == S_SCAN)
    else $error("token left the chain outside a walk");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> block_count < CNT_W'(MAX_BLOCKS))
    else $error("append into a full table");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != STAT_OK |-> rsp.addr == '0 && !rsp.reused)
    else $error("failed transaction carries an address");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(wr_en) && !$past(rst) |-> block_count == $past(block_count) + CNT_W'(1))
    else $error("append did not grow the table");

endmodule

`default_nettype wire

FILE: hw/rtl/ffba_cell.sv
// one table entry of the allocator: start, size and free mark, plus one token stage
// depends on ffba_pkg; instantiated in a row by first_fit_block_allocator
`default_nettype none

module ffba_cell import ffba_pkg::*; #(
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7,
  parameter int SIZE_BITS = 24,
  parameter int IDX       = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire logic [ADDR_W-1:0]    wr_start,
  input  wire logic [SIZE_BITS-1:0] wr_size,
  input  wire ffba_tok_t            tok_in,
  input  wire logic [ADDR_W-1:0]    key_in,
  input  wire logic [ADDR_W-1:0]    found_in,
  output ffba_tok_t                 tok_out,
  output logic [ADDR_W-1:0]         key_out,
  output logic [ADDR_W-1:0]         found_out
);

  logic [ADDR_W-1:0]    start;
  logic [SIZE_BITS-1:0] size;
  logic                 free;
  logic                 active;
  logic                 hit_here;
  ffba_tok_t            tok_next;

  // entries at or above the fill count hold nothing yet
  assign active = CNT_W'(IDX) < count;

  always_comb begin
    hit_here = 1'b0;
    if (tok_in.valid && tok_in.seek && !tok_in.hit && active) begin
      if (tok_in.func == FUNC_ALLOC) begin
        hit_here = free && (ADDR_W'(size) >= key_in);
      end else begin
        hit_here = (start == key_in);
      end
    end
  end

  always_comb begin
    tok_next     = tok_in;
    tok_next.hit = tok_in.hit | hit_here;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    key_out   <= key_in;
    found_out <= hit_here ? start : found_in;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(IDX))) begin
      start <= wr_start;
      size  <= wr_size;
      free  <= 1'b0;
    end else if (hit_here) begin
      free <= (tok_in.func == FUNC_FREE);
    end
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// self-checking bench for the first-fit block allocator: directed and random
// requests, APB register writes between phases, results checked against a shadow heap
// depends on ffba_pkg, ffba_if and first_fit_block_allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int HDR_BYTES      = 12;
  localparam int SIZE_W         = 24;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 2 * (TABLE_DEPTH + 3);
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASE_ITEMS    = 200;
  localparam int RANDOM_PHASES  = 7;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
    logic                reused;
  } alloc_result_t;

  // shadow of the block table plus the results still owed by the block
  class heap_mirror;
    logic [ADDR_W-1:0] blk_start [TABLE_DEPTH];
    logic [REQ_W-1:0]  blk_size  [TABLE_DEPTH];
    bit                blk_free  [TABLE_DEPTH];
    int unsigned       blk_count;
    logic [ADDR_W-1:0] brk;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
    alloc_result_t     owed[$];
    int unsigned       errors;

    function new();
      blk_count = 0;
      brk       = '0;
      base      = HEAP_BASE_RESET;
      limit     = HEAP_LIMIT_RESET;
      errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_HEAP_BASE) begin
        base = value;
      end else begin
        limit = value;
      end
    endfunction

    function alloc_result_t predict_alloc(logic [REQ_W-1:0] req);
      logic [ROUND_W-1:0] rounded;
      logic [ADDR_W-1:0]  at;
      logic [BRK_W-1:0]   next_brk;
      alloc_result_t      r;
      r = '0;
      if (req == '0) begin
        r.status = STAT_NULL;
        return r;
      end
      rounded = (ROUND_W'(req) + ROUND_W'(3)) & ~ROUND_W'(3);
      // rounding carried out of the size field
      if (rounded[ROUND_W-1]) begin
        r.status = STAT_LIMIT;
        return r;
      end
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= rounded[REQ_W-1:0]) begin
          blk_free[i] = 1'b0;
          r.addr   = blk_start[i] + ADDR_W'(HDR_BYTES);
          r.status = STAT_OK;
          r.reused = 1'b1;
          return r;
        end
      end
      if (blk_count >= TABLE_DEPTH) begin
        r.status = STAT_FULL;
        return r;
      end
      at = (blk_count == 0) ? base : brk;
      next_brk = BRK_W'(at) + BRK_W'(HDR_BYTES) + BRK_W'(rounded);
      if (next_brk > BRK_W'(limit)) begin
        r.status = STAT_LIMIT;
        return r;
      end
      blk_start[blk_count] = at;
      blk_size[blk_count]  = rounded[REQ_W-1:0];
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      brk      = next_brk[ADDR_W-1:0];
      r.addr   = at + ADDR_W'(HDR_BYTES);
      r.status = STAT_OK;
      return r;
    endfunction

    function alloc_result_t predict_free(logic [ADDR_W-1:0] payload);
      logic [ADDR_W-1:0] hdr;
      alloc_result_t     r;
      r = '0;
      if (payload == '0) begin
        r.status = STAT_NULL;
        return r;
      end
      hdr = payload - ADDR_W'(HDR_BYTES);
      for (int i = 0; i < blk_count; i++) begin
        if (blk_start[i] == hdr) begin
          blk_free[i] = 1'b1;
          r.status = STAT_OK;
          return r;
        end
      end
      r.status = STAT_UNKNOWN;
      return r;
    endfunction

    function void accept_request(logic func, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] payload);
      if (func == FUNC_ALLOC) begin
        owed.push_back(predict_alloc(size));
      end else begin
        owed.push_back(predict_free(payload));
      end
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status,
                               logic reused);
      alloc_result_t exp;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual addr %h status %0d",
                 $time, addr, status);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (addr !== exp.addr) begin
        $display("%0t: addr mismatch, expected %h, actual %h", $time, exp.addr, addr);
        errors++;
      end
      if (status !== exp.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, exp.status, status);
        errors++;
      end
      if (reused !== exp.reused) begin
        $display("%0t: reused mismatch, expected %b, actual %b", $time, exp.reused, reused);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  bit                calm;
  int unsigned       cycles;
  heap_mirror        ledger;

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();

  first_fit_block_allocator #(
    .MAX_BLOCKS  (TABLE_DEPTH),
    .HEADER_BYTES(HDR_BYTES),
    .SIZE_BITS   (SIZE_W)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // both channels sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        ledger.accept_request(req_ch.func, req_ch.req_size, req_ch.free_addr);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        ledger.check_result(rsp_ch.addr, rsp_ch.status, rsp_ch.reused);
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin : rsp_stall
    int unsigned stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // returns at the edge where the transaction is accepted
  task automatic push_item(input logic func, input logic [REQ_W-1:0] size,
                           input logic [ADDR_W-1:0] payload);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= func;
    req_ch.req_size  <= size;
    req_ch.free_addr <= payload;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic alloc_item(input logic [REQ_W-1:0] size);
    push_item(FUNC_ALLOC, size, ADDR_W'($urandom()));
  endtask

  task automatic free_item(input logic [ADDR_W-1:0] payload);
    push_item(FUNC_FREE, REQ_W'($urandom()), payload);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    // let the monitor log the last accepted transaction first
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_reg(idx, value);
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    int unsigned      roll;
    int unsigned      idx;
    logic [REQ_W-1:0] s;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      s = '0;
    end else if (roll < 6) begin
      s = 24'hFFFFFC + REQ_W'($urandom_range(0, 3));
    end else if (roll < 12) begin
      s = REQ_W'($urandom());
    end else if (roll < 26 && ledger.blk_count > 0) begin
      // aim at an existing block so reuse gets hit
      idx = $urandom_range(0, ledger.blk_count - 1);
      s = ledger.blk_size[idx] - REQ_W'($urandom_range(0, 3));
    end else if (roll < 76) begin
      s = REQ_W'($urandom_range(1, 64));
    end else begin
      s = REQ_W'($urandom_range(1, 4096));
    end
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_payload();
    int unsigned       roll;
    int unsigned       idx;
    logic [ADDR_W-1:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      a = '0;
    end else if (roll < 15 || ledger.blk_count == 0) begin
      a = ADDR_W'($urandom());
    end else begin
      idx = $urandom_range(0, ledger.blk_count - 1);
      a = ledger.blk_start[idx] + ADDR_W'(HDR_BYTES);
      // near misses, or an exact hit, around a table block's payload
      if (roll < 25) begin
        a = a + ADDR_W'($urandom_range(0, 6)) - ADDR_W'(3);
      end
    end
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] limit_above_break(int unsigned window);
    logic [ADDR_W:0] sum;
    sum = {1'b0, ledger.brk} + (ADDR_W + 1)'(window);
    return sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
  endfunction

  initial begin : stimulus
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] lim;
    ledger           = new();
    calm             = 1'b0;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = FUNC_ALLOC;
    req_ch.req_size  = '0;
    req_ch.free_addr = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base at the very top: every append overruns
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    alloc_item(24'd1);
    alloc_item(24'd0);
    free_item(32'd0);
    free_item(32'hFFFF_FFFF);
    alloc_item(24'hFFFFFF);
    alloc_item(24'hFFFFFD);
    drain();

    write_reg(REG_HEAP_BASE, 32'h0);
    write_reg(REG_HEAP_LIMIT, 32'h0);
    alloc_item(24'd4);
    free_item(32'd12);
    drain();

    // limit leaves room for exactly one 8 byte block
    b = ADDR_W'($urandom_range(0, 32'h0FFF_FFFF));
    write_reg(REG_HEAP_BASE, b);
    write_reg(REG_HEAP_LIMIT, b + 32'd20);
    alloc_item(24'd9);
    alloc_item(24'd8);
    alloc_item(24'd1);
    free_item(b + 32'd12);
    free_item(b + 32'd12);
    alloc_item(24'd5);
    drain();

    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    alloc_item(24'hFFFFFC);
    alloc_item(24'd3);
    free_item(b + 32'd16);
    free_item(32'd5);
    free_item(b + 32'd32);
    alloc_item(24'hFFFFFC);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == RANDOM_PHASES - 1);
      case (p)
        0: lim = limit_above_break($urandom_range(0, 4000));
        1: lim = ledger.brk;
        2: lim = '0;
        3: lim = 32'hFFFF_FFFF;
        4: lim = ADDR_W'($urandom());
        5: lim = limit_above_break($urandom_range(0, 100000));
        default: lim = 32'hFFFF_FFFF;
      endcase
      // base is ignored once the table holds blocks
      write_reg(REG_HEAP_BASE, ADDR_W'($urandom()));
      write_reg(REG_HEAP_LIMIT, lim);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 42) begin
          free_item(pick_payload());
        end else begin
          alloc_item(pick_size());
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
